FILE: src/gift64_block_cipher_unit_defines.svh
// Assertion helpers shared by the cipher unit.
`ifndef GIFT64_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define GIFT64_BLOCK_CIPHER_UNIT_DEFINES_SVH

// Clocked check that is switched off while reset is high.
`define GIFT64_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define GIFT64_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/gift64_pkg.sv
`timescale 1ns / 1ps

package gift64_pkg;

  localparam int NUM_ROUNDS = 28;

  // configuration register indexes
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  localparam logic [3:0] SBOX_FWD [16] = '{
    4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
    4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he
  };
  localparam logic [3:0] SBOX_INV [16] = '{
    4'hd, 4'h0, 4'h8, 4'h6, 4'h2, 4'hc, 4'h4, 4'hb,
    4'he, 4'h7, 4'h1, 4'ha, 4'h3, 4'h9, 4'hf, 4'h5
  };

  // round constants from the 6-bit LFSR, round 0 first
  localparam logic [5:0] RC_TABLE [28] = '{
    6'h01, 6'h03, 6'h07, 6'h0f, 6'h1f, 6'h3e, 6'h3d, 6'h3b,
    6'h37, 6'h2f, 6'h1e, 6'h3c, 6'h39, 6'h33, 6'h27, 6'h0e,
    6'h1d, 6'h3a, 6'h35, 6'h2b, 6'h16, 6'h2c, 6'h18, 6'h30,
    6'h21, 6'h02, 6'h05, 6'h0b
  };

  typedef struct packed {
    logic valid;
    logic func;
  } gift64_ctrl_t;

  // round key words for one round: u goes to nibble bit 1, v to nibble bit 0
  typedef struct packed {
    logic [15:0] u;
    logic [15:0] v;
    logic [5:0]  rc;
  } gift64_rkey_t;

  function automatic logic [5:0] perm_dest(input int unsigned i);
    int unsigned q;
    int unsigned m;
    int unsigned d;
    q = (i >> 2) & 32'd3;
    m = i & 32'd3;
    d = ((i >> 4) << 2) + (((3 * q + m) & 32'd3) << 4) + m;
    return d[5:0];
  endfunction

  function automatic logic [63:0] sub_fwd(input logic [63:0] x);
    logic [63:0] y;
    for (int j = 0; j < 16; j++) begin
      y[4*j +: 4] = SBOX_FWD[x[4*j +: 4]];
    end
    return y;
  endfunction

  function automatic logic [63:0] sub_inv(input logic [63:0] x);
    logic [63:0] y;
    for (int j = 0; j < 16; j++) begin
      y[4*j +: 4] = SBOX_INV[x[4*j +: 4]];
    end
    return y;
  endfunction

  function automatic logic [63:0] perm_fwd(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) begin
      y[perm_dest(i)] = x[i];
    end
    return y;
  endfunction

  function automatic logic [63:0] perm_inv(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) begin
      y[i] = x[perm_dest(i)];
    end
    return y;
  endfunction

  function automatic logic [63:0] add_round(input logic [63:0] x, input gift64_rkey_t rk);
    logic [63:0] y;
    y = x;
    for (int j = 0; j < 16; j++) begin
      y[4*j]     = y[4*j] ^ rk.v[j];
      y[4*j + 1] = y[4*j + 1] ^ rk.u[j];
    end
    for (int j = 0; j < 6; j++) begin
      y[4*j + 3] = y[4*j + 3] ^ rk.rc[j];
    end
    y[63] = ~y[63];
    return y;
  endfunction

  // key words and constant for round r; r is fixed per cell, so this is wiring
  function automatic gift64_rkey_t round_key(input logic [127:0] key, input int r);
    logic [15:0] w [8];
    logic [15:0] t0;
    logic [15:0] t1;
    gift64_rkey_t rk;
    for (int i = 0; i < 8; i++) begin
      w[i] = key[16*i +: 16];
    end
    for (int k = 0; k < NUM_ROUNDS; k++) begin
      if (k < r) begin
        t0 = w[0];
        t1 = w[1];
        for (int i = 0; i < 6; i++) begin
          w[i] = w[i + 2];
        end
        w[6] = {t0[11:0], t0[15:12]};
        w[7] = {t1[1:0], t1[15:2]};
      end
    end
    rk.u  = w[1];
    rk.v  = w[0];
    rk.rc = RC_TABLE[r];
    return rk;
  endfunction

endpackage

FILE: src/gift64_block_cipher_unit.sv
`timescale 1ns / 1ps
// GIFT-64-128 cipher unit, one block per clock.
// Load the key with cfg_we / cfg_addr / cfg_data: index 0 is key_low, index 1
// is key_high. Write the key only while no block is in flight.
// A block transfer happens at a rising edge with start high and busy low;
// func selects encrypt (0) or decrypt (1), block_in carries the block.
// The block walks a row of 28 round cells, one round per cell per cycle, and
// each cell registers its round; done and block_out come from the last cell.
// A new block can be started in every cycle while busy is low; throughput
// is then one block per cycle and results leave in start order.
// done lasts one cycle and the receiver takes the result then; there is no
// way to hold it off.
// Reset (rst, synchronous) clears the key to zero and drops every block in
// flight; busy is high in the cycle after reset is applied and low once
// the unit runs.
// Decryption runs the same row with inverse rounds, last round key first.

module gift64_block_cipher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [63:0] block_in,
  output logic        done,
  output logic [63:0] block_out,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_data
);
  import gift64_pkg::*;

  `include "gift64_block_cipher_unit_defines.svh"

  logic [63:0]  key_low;
  logic [63:0]  key_high;
  logic [127:0] key;

  gift64_ctrl_t ctrl [NUM_ROUNDS + 1];
  logic [63:0]  blk  [NUM_ROUNDS + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      busy     <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_KEY_LOW:  key_low  <= cfg_data;
          REG_KEY_HIGH: key_high <= cfg_data;
          default:      ;
        endcase
      end
    end
  end

  assign key = {key_high, key_low};

  assign ctrl[0].valid = start & ~busy;
  assign ctrl[0].func  = func;
  assign blk[0]        = block_in;

  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
    gift64_rkey_t rk_enc;
    gift64_rkey_t rk_dec;

    // encryption walks rounds upward, decryption downward
    assign rk_enc = round_key(key, g);
    assign rk_dec = round_key(key, NUM_ROUNDS - 1 - g);

    gift64_round_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl_in    (ctrl[g]),
      .block_prev (blk[g]),
      .rk_enc     (rk_enc),
      .rk_dec     (rk_dec),
      .ctrl_out   (ctrl[g + 1]),
      .block_cur  (blk[g + 1])
    );
  end

  assign done      = ctrl[NUM_ROUNDS].valid;
  assign block_out = blk[NUM_ROUNDS];

  `GIFT64_ASSERT(a_busy_low_after_reset, !$past(rst) |-> !busy, "busy high outside reset")
  `GIFT64_ASSERT(a_done_has_start, done |-> $past(start && !busy, NUM_ROUNDS), "done without start")
  `GIFT64_ASSERT_ALWAYS(a_reset_flush, $past(rst) |-> !done, "done right after reset")

endmodule

FILE: src/gift64_round_cell.sv
`timescale 1ns / 1ps

module gift64_round_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  gift64_pkg::gift64_ctrl_t  ctrl_in,
  input  logic [63:0]               block_prev,
  input  gift64_pkg::gift64_rkey_t  rk_enc,
  input  gift64_pkg::gift64_rkey_t  rk_dec,
  output gift64_pkg::gift64_ctrl_t  ctrl_out,
  output logic [63:0]               block_cur
);
  import gift64_pkg::*;

  logic [63:0] enc_next;
  logic [63:0] dec_next;

  always_comb begin
    enc_next = add_round(perm_fwd(sub_fwd(block_prev)), rk_enc);
    dec_next = sub_inv(perm_inv(add_round(block_prev, rk_dec)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_in.func == FUNC_DEC) begin
      block_cur <= dec_next;
    end else begin
      block_cur <= enc_next;
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gift64_pkg::*;

  localparam int LATENCY         = 28;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int REPORT_LIMIT    = 10;

  localparam logic [3:0] GIFT_S [16] = '{
    4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
    4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he
  };
  localparam logic [3:0] GIFT_S_INV [16] = '{
    4'hd, 4'h0, 4'h8, 4'h6, 4'h2, 4'hc, 4'h4, 4'hb,
    4'he, 4'h7, 4'h1, 4'ha, 4'h3, 4'h9, 4'hf, 4'h5
  };

  // key_sel 0 is the reset key, so the first rows run without any write
  localparam logic [127:0] KEY_SET [4] = '{
    128'h0,
    {128{1'b1}},
    128'h0123456789abcdef_fedcba9876543210,
    128'h80000000000000000000000000000001
  };

  typedef struct packed {
    logic [1:0]  key_sel;
    logic        dir;
    logic [63:0] blk;
  } cipher_vec_t;

  localparam int NUM_DIRECTED = 20;
  localparam cipher_vec_t DIRECTED [NUM_DIRECTED] = '{
    '{2'd0, FUNC_ENC, 64'h0000000000000000},
    '{2'd0, FUNC_ENC, 64'hffffffffffffffff},
    '{2'd0, FUNC_DEC, 64'h0000000000000000},
    '{2'd0, FUNC_DEC, 64'hffffffffffffffff},
    '{2'd0, FUNC_ENC, 64'h8000000000000000},
    '{2'd0, FUNC_ENC, 64'h0000000000000001},
    '{2'd1, FUNC_ENC, 64'h0000000000000000},
    '{2'd1, FUNC_ENC, 64'hffffffffffffffff},
    '{2'd1, FUNC_DEC, 64'h0000000000000000},
    '{2'd1, FUNC_DEC, 64'hffffffffffffffff},
    '{2'd2, FUNC_ENC, 64'h0123456789abcdef},
    '{2'd2, FUNC_DEC, 64'hfedcba9876543210},
    '{2'd2, FUNC_ENC, 64'h5555555555555555},
    '{2'd2, FUNC_ENC, 64'haaaaaaaaaaaaaaaa},
    '{2'd3, FUNC_ENC, 64'h0000000000000000},
    '{2'd3, FUNC_DEC, 64'h0000000000000000},
    '{2'd3, FUNC_ENC, 64'h0f0f0f0f0f0f0f0f},
    '{2'd3, FUNC_DEC, 64'hf0f0f0f0f0f0f0f0},
    '{2'd0, FUNC_ENC, 64'h0000000000000000},
    '{2'd0, FUNC_DEC, 64'h0000000000000000}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        func;
  logic [63:0] block_in;
  logic        done;
  logic [63:0] block_out;
  logic        cfg_we;
  logic        cfg_addr;
  logic [63:0] cfg_data;

  logic [127:0] active_key;
  logic [63:0]  expected_blocks [$];
  logic [63:0]  want_block;
  int           fail_cnt = 0;

  gift64_block_cipher_unit DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .block_in(block_in),
    .done(done),
    .block_out(block_out),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] sub_nibbles(input logic [63:0] x, input logic inv);
    logic [63:0] y;
    for (int n = 0; n < 16; n++) begin
      y[4*n +: 4] = inv ? GIFT_S_INV[x[4*n +: 4]] : GIFT_S[x[4*n +: 4]];
    end
    return y;
  endfunction

  // bit i of nibble column i/4 lands in the same slice, rotated by nibble position
  function automatic int bit_dest(input int i);
    return 4 * (i / 16) + 16 * ((3 * ((i % 16) / 4) + i % 4) % 4) + i % 4;
  endfunction

  function automatic logic [63:0] permute_bits(input logic [63:0] x, input logic inv);
    logic [63:0] y;
    y = '0;
    for (int i = 0; i < 64; i++) begin
      if (inv) begin
        y[i] = x[bit_dest(i)];
      end else begin
        y[bit_dest(i)] = x[i];
      end
    end
    return y;
  endfunction

  function automatic logic [63:0] mix_round_key(input logic [63:0] x, input logic [15:0] u,
                                                input logic [15:0] v, input logic [5:0] c);
    logic [63:0] y;
    y = x;
    for (int j = 0; j < 16; j++) begin
      y[4*j]     ^= v[j];
      y[4*j + 1] ^= u[j];
    end
    for (int j = 0; j < 6; j++) begin
      y[4*j + 3] ^= c[j];
    end
    y[63] = ~y[63];
    return y;
  endfunction

  function automatic logic [63:0] gift_cipher(input logic [127:0] key, input logic dir,
                                              input logic [63:0] blk);
    logic [15:0] kw [8];
    logic [15:0] ru [NUM_ROUNDS];
    logic [15:0] rv [NUM_ROUNDS];
    logic [5:0]  rcon [NUM_ROUNDS];
    logic [15:0] t0;
    logic [15:0] t1;
    logic [5:0]  lfsr;
    logic [63:0] x;
    for (int i = 0; i < 8; i++) begin
      kw[i] = key[16*i +: 16];
    end
    lfsr = '0;
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      rv[r] = kw[0];
      ru[r] = kw[1];
      lfsr = {lfsr[4:0], lfsr[5] ^ lfsr[4] ^ 1'b1};
      rcon[r] = lfsr;
      t0 = kw[0];
      t1 = kw[1];
      for (int i = 0; i < 6; i++) begin
        kw[i] = kw[i + 2];
      end
      kw[6] = {t0[11:0], t0[15:12]};
      kw[7] = {t1[1:0], t1[15:2]};
    end
    x = blk;
    if (dir == FUNC_ENC) begin
      for (int r = 0; r < NUM_ROUNDS; r++) begin
        x = sub_nibbles(x, 1'b0);
        x = permute_bits(x, 1'b0);
        x = mix_round_key(x, ru[r], rv[r], rcon[r]);
      end
    end else begin
      for (int r = NUM_ROUNDS - 1; r >= 0; r--) begin
        x = mix_round_key(x, ru[r], rv[r], rcon[r]);
        x = permute_bits(x, 1'b1);
        x = sub_nibbles(x, 1'b1);
      end
    end
    return x;
  endfunction

  function automatic logic [63:0] pick_block();
    case ($urandom_range(0, 9))
      0: return 64'h1 << $urandom_range(0, 63);
      1: return ~(64'h1 << $urandom_range(0, 63));
      2: return $urandom_range(0, 1) ? {64{1'b1}} : 64'h0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // hold start high across back-to-back transfers; drop it only for a gap
  task automatic send_block(input logic dir, input logic [63:0] blk, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    func     <= dir;
    block_in <= blk;
    do @(posedge clk); while (busy !== 1'b0);
    expected_blocks.push_back(gift_cipher(active_key, dir, blk));
  endtask

  // write the key only once the pipeline has emptied
  task automatic load_key(input logic [127:0] key);
    start <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_KEY_LOW;
    cfg_data <= key[63:0];
    @(posedge clk);
    cfg_addr <= REG_KEY_HIGH;
    cfg_data <= key[127:64];
    @(posedge clk);
    cfg_we <= 1'b0;
    active_key = key;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_blocks.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_LIMIT) begin
          $display("unexpected result: block_out %h", block_out);
        end
      end else begin
        want_block = expected_blocks.pop_front();
        if (block_out !== want_block) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_LIMIT) begin
            $display("block_out mismatch: expected %h, got %h", want_block, block_out);
          end
        end
      end
    end
  end

  initial begin
    logic [1:0]  cur_sel;
    logic [63:0] last_ct;
    logic [63:0] blk;
    logic        dir;
    bit          burst;
    start    <= 1'b0;
    func     <= FUNC_ENC;
    block_in <= '0;
    cfg_we   <= 1'b0;
    cfg_addr <= REG_KEY_LOW;
    cfg_data <= '0;
    rst      <= 1'b1;
    active_key = '0;
    cur_sel    = 2'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED[i].key_sel != cur_sel) begin
        cur_sel = DIRECTED[i].key_sel;
        load_key(KEY_SET[cur_sel]);
      end
      send_block(DIRECTED[i].dir, DIRECTED[i].blk, pick_gap(1'b0));
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      burst = (ph == 0) || ($urandom_range(0, 3) == 0);
      load_key({pick_block(), pick_block()});
      last_ct = pick_block();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        dir = $urandom_range(0, 1) ? FUNC_DEC : FUNC_ENC;
        blk = pick_block();
        // feed back a recent ciphertext now and then to close the round trip
        if (dir == FUNC_DEC && $urandom_range(0, 2) == 0) begin
          blk = last_ct;
        end
        send_block(dir, blk, pick_gap(burst));
        if (dir == FUNC_ENC) begin
          last_ct = gift_cipher(active_key, FUNC_ENC, blk);
        end
      end
    end

    start <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/gift64_pkg.sv
src/gift64_round_cell.sv
src/gift64_block_cipher_unit.sv
tb/testbench.sv
